/* design/sct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the star command tokeniser
// Character codes, scanner phase codes, the scanner state record and the
// layout of one result word.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int ByteW   = 8;
    localparam int LetterW = 7;
    localparam int ValueW  = 31;
    localparam int PhaseW  = 2;
    localparam int OutDataW = 40;   // letter, value and flag, padded to whole bytes

    localparam logic [ValueW-1:0] VALUE_MAX = {ValueW{1'b1}};

    // Characters of interest
    localparam logic [ByteW-1:0] CHAR_STAR = 8'h2A;
    localparam logic [ByteW-1:0] CHAR_0    = 8'h30;
    localparam logic [ByteW-1:0] CHAR_9    = 8'h39;
    localparam logic [ByteW-1:0] CHAR_A    = 8'h41;
    localparam logic [ByteW-1:0] CHAR_D    = 8'h44;
    localparam logic [ByteW-1:0] CHAR_F    = 8'h46;
    localparam logic [ByteW-1:0] CHAR_I    = 8'h49;
    localparam logic [ByteW-1:0] CHAR_P    = 8'h50;
    localparam logic [ByteW-1:0] CHAR_Q    = 8'h51;
    localparam logic [ByteW-1:0] CHAR_R    = 8'h52;
    localparam logic [ByteW-1:0] CHAR_T    = 8'h54;

    // Scanner phases
    localparam logic [PhaseW-1:0] PH_IDLE   = 2'd0;
    localparam logic [PhaseW-1:0] PH_STAR   = 2'd1;
    localparam logic [PhaseW-1:0] PH_LETTER = 2'd2;
    localparam logic [PhaseW-1:0] PH_DIGITS = 2'd3;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [ByteW-1:0]  held_letter;
        logic [ValueW-1:0] value_accumulator;
        logic              overflow_seen;
    } scan_state_t;

    typedef struct packed {
        logic              value_overflow;
        logic [ValueW-1:0] command_value;
        logic [LetterW-1:0] command_letter;
    } result_t;

    localparam scan_state_t SCAN_RESET = '{
        phase: PH_IDLE, held_letter: '0, value_accumulator: '0, overflow_seen: 1'b0
    };

endpackage
`default_nettype wire

/* design/star_command_tokenizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// star_command_tokenizer: finds '*'-letter-digits commands in a byte stream
// Each command leaves as one word carrying its letter, its decimal value
// (saturated) and an overflow flag.
//
//  Channel | Dir | Ports                          | Content
//  --------+-----+--------------------------------+-----------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tlast | one text byte, end of string
//  m_      | out | m_tvalid m_tready m_tdata      | letter, value, overflow flag
//
// One byte is taken every cycle unless the spare result slot is full; the byte
// that completes a command passes the input register, then the scanner and result register.
// The scanner update itself is combinational: one multiply-by-ten add and
// compare on the 31-bit accumulator.
// Reset is synchronous on aresetn low and returns the scanner to idle.
// A stalled output is covered by a second result slot, so bytes keep flowing
// until both slots are full.
// ----------------------------------------------------------------------------
module star_command_tokenizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [6:0] command_letter, [37:7] command_value,
                                        // [38] value_overflow, [39] zero
);
    import sct_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    logic        step_emit;
    result_t     step_result;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        skid_valid_reg;
    result_t     skid_reg;
    logic        step_fire;
    logic        in_fire;
    logic        m_fire;

    // The scanner works on the registered byte whenever the spare slot is free
    assign step_fire = in_valid_reg && !skid_valid_reg;
    assign s_tready  = !in_valid_reg || step_fire;
    assign in_fire   = s_tvalid && s_tready;
    assign m_fire    = out_valid_reg && m_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    sct_step u_step (
        .cur_state  (state_reg),
        .text_byte  (in_byte_reg),
        .end_of_text(in_last_reg),
        .next_state (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_RESET;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    // Result slot and spare slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (out_valid_reg && !m_tready) begin
            if (step_fire && step_emit) begin
                skid_valid_reg <= 1'b1;
            end
        end else begin
            out_valid_reg <= step_fire && step_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_reg <= skid_reg;
            end
        end else if (out_valid_reg && !m_tready) begin
            if (step_fire && step_emit) begin
                skid_reg <= step_result;
            end
        end else if (step_fire && step_emit) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.value_overflow, out_reg.command_value,
                       out_reg.command_letter};

endmodule
`default_nettype wire

/* design/sct_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_step: one-byte update of the command scanner
// Given the current scanner state and one byte, works out the next state and
// whether a finished command leaves with this byte.
// ----------------------------------------------------------------------------
module sct_step (
    input  wire sct_pkg::scan_state_t cur_state,
    input  wire logic [7:0]       text_byte,
    input  wire logic             end_of_text,
    output sct_pkg::scan_state_t  next_state,
    output logic                  emit,
    output sct_pkg::result_t      result
);
    import sct_pkg::*;

    logic              is_digit;
    logic              is_letter;
    logic              is_star;
    logic [ValueW-1:0] acc_base;
    logic              ovf_base;
    logic [ValueW+3:0] acc_ext;
    logic [ValueW+3:0] acc_sum;
    logic              saturate;
    logic              run_end;
    scan_state_t       upd;

    // Character classes; bytes of 128 and up fall in none of them
    always_comb begin
        is_digit  = text_byte inside {[CHAR_0:CHAR_9]};
        is_letter = text_byte inside {CHAR_A, CHAR_F, CHAR_D, CHAR_I,
                                      CHAR_P, CHAR_R, CHAR_Q, CHAR_T};
        is_star   = (text_byte == CHAR_STAR);
    end

    // Decimal accumulate: value * 10 + digit, a fresh run starts from zero
    always_comb begin
        acc_base = (cur_state.phase == PH_DIGITS) ? cur_state.value_accumulator : '0;
        ovf_base = (cur_state.phase == PH_DIGITS) ? cur_state.overflow_seen : 1'b0;
        acc_ext  = {4'b0000, acc_base};
        acc_sum  = (acc_ext << 3) + (acc_ext << 1) + {{(ValueW){1'b0}}, text_byte[3:0]};
        saturate = (acc_sum > {4'b0000, VALUE_MAX});
    end

    // Phase transitions
    always_comb begin
        upd     = cur_state;
        run_end = 1'b0;
        case (cur_state.phase)
            PH_STAR: begin
                if (is_letter) begin
                    upd.held_letter = text_byte;
                    upd.phase       = PH_LETTER;
                end else if (is_star) begin
                    upd.phase = PH_STAR;
                end else begin
                    upd.phase = PH_IDLE;
                end
            end
            PH_LETTER, PH_DIGITS: begin
                if (is_digit) begin
                    upd.value_accumulator = saturate ? VALUE_MAX : acc_sum[ValueW-1:0];
                    upd.overflow_seen     = ovf_base | saturate;
                    upd.phase             = PH_DIGITS;
                end else begin
                    run_end   = (cur_state.phase == PH_DIGITS);
                    upd.phase = is_star ? PH_STAR : PH_IDLE;
                end
            end
            default: begin
                upd.phase = is_star ? PH_STAR : PH_IDLE;
            end
        endcase

        // A run still open at the end of the string leaves as well
        emit = run_end || (end_of_text && (upd.phase == PH_DIGITS));

        result.command_letter = upd.held_letter[LetterW-1:0];
        result.command_value  = upd.value_accumulator;
        result.value_overflow = upd.overflow_seen;

        next_state = end_of_text ? SCAN_RESET : upd;
    end

endmodule
`default_nettype wire

/* design/sct_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_checker: port-level checks for the star command tokeniser
// Watches the result channel and checks the content of each word, plus input readiness.
// ----------------------------------------------------------------------------
module sct_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);
    import sct_pkg::*;

    logic [6:0] letter;
    assign letter = m_tdata[6:0];

    // A stalled word stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    // Every word carries one of the eight command letters
    a_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (letter == CHAR_A[6:0] || letter == CHAR_F[6:0] ||
                      letter == CHAR_D[6:0] || letter == CHAR_I[6:0] ||
                      letter == CHAR_P[6:0] || letter == CHAR_R[6:0] ||
                      letter == CHAR_Q[6:0] || letter == CHAR_T[6:0]))
        else $error("result word with a letter that is not a command");

    // An overflowed value is held at the maximum, and the pad bit is zero
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[38] || m_tdata[37:7] == VALUE_MAX) && !m_tdata[39])
        else $error("overflow flag without saturated value");

    // Nothing leaves right after reset, since no byte has been taken
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word straight after reset");

    // Input is never refused while the block holds no pending work at all
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && $past(!s_tvalid) && $past(aresetn) |-> s_tready)
        else $error("input refused with nothing pending");

endmodule

bind star_command_tokenizer sct_checker u_sct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for star_command_tokenizer
// A queue of text words is built up front: a short directed part, then random
// command strings mixed with broken sequences and noise. A clocked driver
// offers the words and models the expected commands as each word is taken; a
// clocked monitor compares every result word with the oldest expected command.
// ----------------------------------------------------------------------------
module testbench;
    import sct_pkg::*;

    localparam int RandomWords = 1900;
    localparam int StallLimit  = 3000;
    localparam int HoldCycles  = 400;

    typedef struct packed {
        logic [ByteW-1:0] ch;
        logic             is_last;
    } text_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;

    text_word_t pending_words[$];
    result_t    expected_cmds[$];
    int         total_words = 0;
    int         words_taken = 0;
    int         fail_count  = 0;
    int         stall_cycles = 0;
    int         hold_left   = 0;
    logic       hold_done   = 1'b0;

    // Scanner state as the bench believes it to be.
    logic [PhaseW-1:0] scan_phase  = PH_IDLE;
    logic [ByteW-1:0]  scan_letter = '0;
    logic [ValueW-1:0] scan_value  = '0;
    logic              scan_ovf    = 1'b0;

    star_command_tokenizer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock, 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic is_cmd_letter(input logic [ByteW-1:0] c);
        return c == CHAR_A || c == CHAR_F || c == CHAR_D || c == CHAR_I ||
               c == CHAR_P || c == CHAR_R || c == CHAR_Q || c == CHAR_T;
    endfunction

    function automatic logic is_digit(input logic [ByteW-1:0] c);
        return c >= CHAR_0 && c <= CHAR_9;
    endfunction

    function automatic logic [ByteW-1:0] pick_letter(input int idx);
        case (idx)
            0: return CHAR_A;
            1: return CHAR_F;
            2: return CHAR_D;
            3: return CHAR_I;
            4: return CHAR_P;
            5: return CHAR_R;
            6: return CHAR_Q;
            default: return CHAR_T;
        endcase
    endfunction

    // Idle rates follow progress: sender light and receiver heavy first,
    // then the other way round, then no idling at all.
    function automatic int send_idle_pct();
        if (words_taken < total_words / 3) return 9;
        if (words_taken < 2 * total_words / 3) return 54;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (words_taken < total_words / 3) return 54;
        if (words_taken < 2 * total_words / 3) return 9;
        return 0;
    endfunction

    // Multiply the running value by ten and add a digit, saturating.
    task automatic accumulate_digit(input logic [ByteW-1:0] c);
        logic [63:0] v;
        v = {33'b0, scan_value} * 64'd10 + {56'b0, c - CHAR_0};
        if (v > {33'b0, VALUE_MAX}) begin
            scan_value = VALUE_MAX;
            scan_ovf   = 1'b1;
        end else begin
            scan_value = v[ValueW-1:0];
        end
    endtask

    task automatic queue_command();
        result_t r;
        r.command_letter = scan_letter[LetterW-1:0];
        r.command_value  = scan_value;
        r.value_overflow = scan_ovf;
        expected_cmds = {expected_cmds, r};
    endtask

    // Advance the scanner by one taken word and note any command it completes.
    task automatic tokenise_byte(input logic [ByteW-1:0] c, input logic is_last);
        logic done;
        done = 1'b0;
        case (scan_phase)
            PH_STAR: begin
                if (is_cmd_letter(c)) begin
                    scan_letter = c;
                    scan_phase  = PH_LETTER;
                end else begin
                    scan_phase = (c == CHAR_STAR) ? PH_STAR : PH_IDLE;
                end
            end
            PH_LETTER: begin
                if (is_digit(c)) begin
                    scan_value = '0;
                    scan_ovf   = 1'b0;
                    accumulate_digit(c);
                    scan_phase = PH_DIGITS;
                end else begin
                    scan_phase = (c == CHAR_STAR) ? PH_STAR : PH_IDLE;
                end
            end
            PH_DIGITS: begin
                if (is_digit(c)) begin
                    accumulate_digit(c);
                end else begin
                    queue_command();
                    done = 1'b1;
                    scan_phase = (c == CHAR_STAR) ? PH_STAR : PH_IDLE;
                end
            end
            default: begin
                scan_phase = (c == CHAR_STAR) ? PH_STAR : PH_IDLE;
            end
        endcase
        // End of text flushes an open digit run and clears everything.
        if (is_last) begin
            if (scan_phase == PH_DIGITS && !done) queue_command();
            scan_phase  = PH_IDLE;
            scan_letter = '0;
            scan_value  = '0;
            scan_ovf    = 1'b0;
        end
    endtask

    task automatic push_word(input logic [ByteW-1:0] c, input logic is_last);
        text_word_t w;
        w.ch      = c;
        w.is_last = is_last;
        pending_words = {pending_words, w};
    endtask

    task automatic push_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++) begin
            push_word(s[i], last_at_end && i == s.len() - 1);
        end
    endtask

    function automatic logic [ByteW-1:0] random_non_digit();
        logic [ByteW-1:0] b;
        b = ByteW'($urandom_range(255));
        while (is_digit(b)) b = ByteW'($urandom_range(255));
        return b;
    endfunction

    // A well-formed command with random letter, digits and ending.
    task automatic push_random_command();
        int n_digits;
        int ending;
        ending = $urandom_range(3);
        push_word(CHAR_STAR, 1'b0);
        push_word(pick_letter($urandom_range(7)), 1'b0);
        if ($urandom_range(15) == 0) begin
            // Right at the saturation boundary, either side of it.
            push_text("214748364", 1'b0);
            push_word(CHAR_0 + ByteW'($urandom_range(9)), ending == 0);
        end else begin
            n_digits = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(6, 1);
            for (int i = 0; i < n_digits; i++) begin
                push_word(CHAR_0 + ByteW'($urandom_range(9)),
                          ending == 0 && i == n_digits - 1);
            end
        end
        // Otherwise the run stays open for whatever word comes next.
        if (ending == 1) push_word(random_non_digit(), $urandom_range(7) == 0);
    endtask

    // Broken sequences that must produce nothing on their own.
    task automatic push_broken_sequence();
        push_word(CHAR_STAR, 1'b0);
        case ($urandom_range(3))
            0: push_word(ByteW'($urandom_range(255)), $urandom_range(3) == 0);
            1: begin
                push_word(pick_letter($urandom_range(7)), 1'b0);
                push_word(random_non_digit(), $urandom_range(3) == 0);
            end
            2: push_word(CHAR_STAR, 1'b1);
            default: begin
                push_word(pick_letter($urandom_range(7)), 1'b1);
            end
        endcase
    endtask

    // Driver: models each taken word, then offers the next one.
    always @(posedge aclk) begin : drive_words
        logic       offer;
        text_word_t w;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tokenise_byte(s_tdata, s_tlast);
                words_taken <= words_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                offer = pending_words.size() != 0 &&
                        $urandom_range(99) >= send_idle_pct();
                if (offer) begin
                    w = pending_words.pop_front();
                    s_tdata <= w.ch;
                    s_tlast <= w.is_last;
                end
                s_tvalid <= offer;
            end
        end
    end

    // Monitor: checks each result word and paces the receiver.
    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[38:0]);
                if (expected_cmds.size() == 0) begin
                    $error("unexpected result word: letter %0d value %0d overflow %0d",
                           got.command_letter, got.command_value, got.value_overflow);
                    fail_count++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.command_letter !== want.command_letter) begin
                        $error("command_letter: expected %0d, got %0d",
                               want.command_letter, got.command_letter);
                        fail_count++;
                    end
                    if (got.command_value !== want.command_value) begin
                        $error("command_value: expected %0d, got %0d",
                               want.command_value, got.command_value);
                        fail_count++;
                    end
                    if (got.value_overflow !== want.value_overflow) begin
                        $error("value_overflow: expected %0d, got %0d",
                               want.value_overflow, got.value_overflow);
                        fail_count++;
                    end
                end
            end
            // One long hold-off while the sender streams without gaps.
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!hold_done && words_taken >= 2 * total_words / 3 + 100) begin
                hold_left <= HoldCycles;
                hold_done <= 1'b1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= $urandom_range(99) >= recv_idle_pct();
            end
        end
    end

    // Watchdog on cycles without any word moving on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= StallLimit) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int directed_words;

        // Directed: digit run opened on the last byte, exact maximum ended by
        // a star, saturation ended by a high byte, letter without digits,
        // invalid letter, run closed by end of text, star as the last byte.
        push_text("*A0", 1'b1);
        push_text("*F2147483647*", 1'b0);
        push_text("D99999999999", 1'b0);
        push_word(8'hFF, 1'b0);
        push_text("*T", 1'b0);
        push_word(8'h80, 1'b0);
        push_text("*Z*P4", 1'b1);
        push_text("*I*", 1'b1);
        directed_words = pending_words.size();

        // Random: mostly well-formed commands, some broken ones and noise.
        while (pending_words.size() < directed_words + RandomWords) begin
            case ($urandom_range(19))
                0, 1, 2:  push_broken_sequence();
                3, 4, 5:  push_word(ByteW'($urandom_range(255)), $urandom_range(7) == 0);
                default:  push_random_command();
            endcase
        end
        total_words = pending_words.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* star_command_tokenizer.f */
design/sct_pkg.sv
design/sct_step.sv
design/star_command_tokenizer.sv
design/sct_checker.sv
tb/testbench.sv
